@@ design/crtc_video_timing_generator_defines.svh @@
// Assertion macros used by the timing generator.
`ifndef CRTC_VIDEO_TIMING_GENERATOR_DEFINES_SVH
`define CRTC_VIDEO_TIMING_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/crtc_vtg_pkg.sv @@
package crtc_vtg_pkg;

  localparam int TICKS_PER_CHAR = 4;
  localparam int REGISTER_COUNT = 32;
  localparam int REG_DEPTH      = 32;
  localparam int REG_IDX_W      = 5;
  localparam int PHASE_W        = (TICKS_PER_CHAR > 1) ? $clog2(TICKS_PER_CHAR) : 1;

  // Bus pages (upper byte of the I/O address).
  localparam logic [7:0] PAGE_SELECT = 8'hBC;
  localparam logic [7:0] PAGE_DATA   = 8'hBD;
  localparam logic [7:0] PAGE_READ   = 8'hBF;

  // Register indexes used by the timing logic.
  localparam int REG_H_TOTAL     = 0;
  localparam int REG_H_DISPLAYED = 1;
  localparam int REG_HSYNC_POS   = 2;
  localparam int REG_SYNC_WIDTHS = 3;
  localparam int REG_V_TOTAL     = 4;
  localparam int REG_V_DISPLAYED = 6;
  localparam int REG_VSYNC_POS   = 7;
  localparam int REG_MAX_RASTER  = 9;
  localparam int REG_START_HI    = 12;
  localparam int REG_START_LO    = 13;

  // Largest height times row distance that still counts as vertical sync.
  localparam int VSYNC_SPAN = 16;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // Timing state and register values the output decode looks at.
  typedef struct packed {
    logic [7:0]  char_column;
    logic [7:0]  raster_row;
    logic [7:0]  char_row;
    logic [15:0] frame_start;
    logic [7:0]  h_displayed;
    logic [7:0]  hsync_pos;
    logic [7:0]  sync_widths;
    logic [7:0]  v_displayed;
    logic [7:0]  vsync_pos;
    logic [7:0]  max_raster;
  } crtc_view_t;

endpackage

@@ design/crtc_vtg_if.sv @@
interface crtc_vtg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] bus_address;
  logic [7:0]  write_data;

  modport source (output valid, kind, bus_address, write_data, input ready);
  modport sink (input valid, kind, bus_address, write_data, output ready);
endinterface

interface crtc_vtg_out_if;
  logic        valid;
  logic        ready;
  logic        hsync;
  logic        vsync;
  logic        display_enable;
  logic [15:0] video_address;
  logic [7:0]  read_data;

  modport source (output valid, hsync, vsync, display_enable, video_address, read_data,
                  input ready);
  modport sink (input valid, hsync, vsync, display_enable, video_address, read_data,
                output ready);
endinterface

@@ design/crtc_vtg_decode.sv @@
module crtc_vtg_decode (
  input  crtc_vtg_pkg::crtc_view_t view_i,
  output logic                     hsync_o,
  output logic                     vsync_o,
  output logic                     display_enable_o,
  output logic [15:0]              video_address_o
);

  logic [8:0]         hs_end;
  logic [7:0]         height;
  logic signed [8:0]  row_diff;
  logic signed [17:0] vs_prod;
  logic [15:0]        row_offset;
  logic [15:0]        linear_addr;

  always_comb begin
    hs_end  = {1'b0, view_i.hsync_pos} + {5'd0, view_i.sync_widths[3:0]};
    hsync_o = (view_i.char_column >= view_i.hsync_pos)
              && ({1'b0, view_i.char_column} < hs_end);

    // Character height wraps to zero when the max raster register is all ones.
    height   = view_i.max_raster + 8'd1;
    row_diff = $signed({1'b0, view_i.char_row}) - $signed({1'b0, view_i.vsync_pos});
    vs_prod  = $signed({1'b0, height}) * row_diff;
    vsync_o  = (vs_prod >= 18'sd0) && (vs_prod <= 18'(crtc_vtg_pkg::VSYNC_SPAN));

    display_enable_o = (view_i.char_column < view_i.h_displayed)
                       && (view_i.char_row < view_i.v_displayed);

    row_offset  = view_i.h_displayed * view_i.char_row;
    linear_addr = view_i.frame_start + row_offset + {8'd0, view_i.char_column};
    video_address_o = {linear_addr[13:12], view_i.raster_row[2:0], linear_addr[9:0], 1'b0};
  end

endmodule

@@ design/crtc_video_timing_generator.sv @@
// Simplified 6845-style CRT timing generator.
// The in_i channel carries one item per transfer: a character clock tick,
// a bus write or a bus read. Writes to page BC pick one of the 32 byte
// registers, writes to page BD load it, and reads from page BF return it.
// Every fourth tick steps the column, raster and character row counters
// against their total registers; the frame start address reloads from
// R12:R13 whenever the counters pass the frame origin.
// The out_o channel returns exactly one transfer per input item, in order,
// holding hsync, vsync, display enable, the scrambled video address and the
// read byte, all as seen after that item took effect.
// The item updates the counters and registers at its transfer edge, and the
// result is registered after that. One item is taken per cycle while the
// receiver takes results; the 8x8 address multiply and the sync compare sit
// between the state registers and the result register.
// When the receiver stalls, the result register holds and one more item may
// still be taken; after that in_i.ready drops until the result is taken.
// Reset clears the register file, select, counters and frame start to zero.
`include "crtc_video_timing_generator_defines.svh"

module crtc_video_timing_generator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  crtc_vtg_in_if.sink           in_i,
  crtc_vtg_out_if.source        out_o
);

  // Register file and its select pointer.
  logic [7:0]                          regs_q [crtc_vtg_pkg::REG_DEPTH];
  logic [crtc_vtg_pkg::REG_IDX_W-1:0]  sel_q, sel_d;
  logic                                reg_wr;

  // Raster counters.
  logic [crtc_vtg_pkg::PHASE_W-1:0]    phase_q, phase_d;
  logic [7:0]                          col_q, col_d;
  logic [7:0]                          raster_q, raster_d;
  logic [7:0]                          row_q, row_d;
  logic [15:0]                         frame_q, frame_d;

  // Stage one holds the post-item state; stage two is the result register.
  logic                                s1_valid_q;
  logic [7:0]                          rd_q, rd_d;
  logic                                s1_adv;
  logic                                in_xfer;
  logic                                out_valid_q;

  crtc_vtg_pkg::kind_e                 kind;
  logic [7:0]                          page;
  logic                                sel_in_range;
  logic                                last_phase;
  logic [7:0]                          adv_col, adv_raster, adv_row;

  crtc_vtg_pkg::crtc_view_t            view;
  logic                                hsync_c, vsync_c, de_c;
  logic [15:0]                         vaddr_c;

  // The state registers only move once the previous item's result has been
  // able to leave stage one, so they always describe the pending item.
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  assign kind         = crtc_vtg_pkg::kind_e'(in_i.kind);
  assign page         = in_i.bus_address[15:8];
  assign sel_in_range = {1'b0, sel_q} < (crtc_vtg_pkg::REG_IDX_W + 1)'(crtc_vtg_pkg::REGISTER_COUNT);
  assign last_phase   = phase_q >= crtc_vtg_pkg::PHASE_W'(crtc_vtg_pkg::TICKS_PER_CHAR - 1);

  // One character step: column, then raster, then character row, each
  // checked against its total even when it did not advance.
  always_comb begin
    adv_col    = col_q + 8'd1;
    adv_raster = raster_q;
    adv_row    = row_q;
    if (adv_col > regs_q[crtc_vtg_pkg::REG_H_TOTAL]) begin
      adv_col    = 8'd0;
      adv_raster = raster_q + 8'd1;
    end
    if (adv_raster > regs_q[crtc_vtg_pkg::REG_MAX_RASTER]) begin
      adv_raster = 8'd0;
      adv_row    = row_q + 8'd1;
    end
    if (adv_row > regs_q[crtc_vtg_pkg::REG_V_TOTAL]) begin
      adv_row = 8'd0;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    col_d    = col_q;
    raster_d = raster_q;
    row_d    = row_q;
    frame_d  = frame_q;
    sel_d    = sel_q;
    reg_wr   = 1'b0;
    rd_d     = 8'd0;
    if (in_xfer) begin
      case (kind)
        crtc_vtg_pkg::KIND_TICK: begin
          if (last_phase) begin
            phase_d  = '0;
            col_d    = adv_col;
            raster_d = adv_raster;
            row_d    = adv_row;
            // Frame origin: latch the new start address.
            if (adv_row == 8'd0 && adv_col == 8'd0) begin
              frame_d = {regs_q[crtc_vtg_pkg::REG_START_HI],
                         regs_q[crtc_vtg_pkg::REG_START_LO]};
            end
          end else begin
            phase_d = phase_q + crtc_vtg_pkg::PHASE_W'(1);
          end
        end
        crtc_vtg_pkg::KIND_WRITE: begin
          if (page == crtc_vtg_pkg::PAGE_SELECT) begin
            sel_d = in_i.write_data[crtc_vtg_pkg::REG_IDX_W-1:0];
          end else if (page == crtc_vtg_pkg::PAGE_DATA) begin
            reg_wr = sel_in_range;
          end
        end
        crtc_vtg_pkg::KIND_READ: begin
          if (page == crtc_vtg_pkg::PAGE_READ && sel_in_range) begin
            rd_d = regs_q[sel_q];
          end
        end
        default: begin
          // The unused kind leaves everything as it is.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < crtc_vtg_pkg::REG_DEPTH; i++) begin
        regs_q[i] <= 8'd0;
      end
      sel_q    <= '0;
      phase_q  <= '0;
      col_q    <= 8'd0;
      raster_q <= 8'd0;
      row_q    <= 8'd0;
      frame_q  <= 16'd0;
    end else begin
      if (reg_wr) begin
        regs_q[sel_q] <= in_i.write_data;
      end
      sel_q    <= sel_d;
      phase_q  <= phase_d;
      col_q    <= col_d;
      raster_q <= raster_d;
      row_q    <= row_d;
      frame_q  <= frame_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // The read byte is captured with the item since the select may change later.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q <= rd_d;
    end
  end

  assign view = '{
    char_column: col_q,
    raster_row:  raster_q,
    char_row:    row_q,
    frame_start: frame_q,
    h_displayed: regs_q[crtc_vtg_pkg::REG_H_DISPLAYED],
    hsync_pos:   regs_q[crtc_vtg_pkg::REG_HSYNC_POS],
    sync_widths: regs_q[crtc_vtg_pkg::REG_SYNC_WIDTHS],
    v_displayed: regs_q[crtc_vtg_pkg::REG_V_DISPLAYED],
    vsync_pos:   regs_q[crtc_vtg_pkg::REG_VSYNC_POS],
    max_raster:  regs_q[crtc_vtg_pkg::REG_MAX_RASTER]
  };

  crtc_vtg_decode u_decode (
    .view_i           (view),
    .hsync_o          (hsync_c),
    .vsync_o          (vsync_c),
    .display_enable_o (de_c),
    .video_address_o  (vaddr_c)
  );

  // Result register: loads whenever stage one hands over an item.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_o.hsync          <= hsync_c;
      out_o.vsync          <= vsync_c;
      out_o.display_enable <= de_c;
      out_o.video_address  <= vaddr_c;
      out_o.read_data      <= rd_q;
    end
  end

  assign out_o.valid = out_valid_q;

  // A stalled stage one must not let the timing state move underneath it.
  `CRTC_ASSERT_NEXT(a_state_held, clk_i, rst_ni, s1_valid_q && !s1_adv,
    $stable(col_q) && $stable(raster_q) && $stable(row_q) && $stable(frame_q),
    "timing state changed while its result was still pending")

  // Every accepted item must occupy stage one on the next cycle.
  `CRTC_ASSERT_NEXT(a_item_tracked, clk_i, rst_ni, in_xfer, s1_valid_q,
    "accepted item lost before reaching the result stage")

  // The last tick of a character must restart the tick phase.
  `CRTC_ASSERT_NEXT(a_phase_wrap, clk_i, rst_ni,
    in_xfer && (kind == crtc_vtg_pkg::KIND_TICK) && last_phase,
    phase_q == '0, "tick phase did not wrap after a character step")

endmodule
